[hdl/vliw_in_order_issue_scoreboard_assert.svh]
// Assertion macros for the issue scoreboard.
// Included by the modules that check their own logic; no other dependencies.
`ifndef VLIW_IN_ORDER_ISSUE_SCOREBOARD_ASSERT_SVH
`define VLIW_IN_ORDER_ISSUE_SCOREBOARD_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define VIIS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scoreboard check failed");
// next-cycle implication, checked out of reset
`define VIIS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scoreboard check failed");
`else
`define VIIS_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define VIIS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[hdl/viis_pkg.sv]
// Shared constants, types and helpers for the VLIW issue scoreboard.
// No dependencies; used by the top level.
package viis_pkg;

   localparam int NUM_REGS   = 32;
   localparam int COUNT_BITS = 32;
   localparam int REG_AW     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int REG_W      = 6;
   localparam int WORD_W     = 32;
   localparam int LAT_W      = 3;
   localparam int WAIT_W     = 3;
   localparam int MAX_WAIT   = 6;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [REG_W-1:0]      reg_field_type;
   typedef logic [REG_AW-1:0]     reg_addr_type;
   typedef logic [LAT_W-1:0]      lat_type;

   localparam count_type CNT_MAX = '1;

   // operation kinds / unit slots
   localparam logic [1:0] KIND_NOP = 2'd0;
   localparam logic [1:0] KIND_ALU = 2'd1;
   localparam logic [1:0] KIND_MUL = 2'd2;
   localparam logic [1:0] KIND_MEM = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_ALU_LAT = 2'd0;
   localparam logic [1:0] CSR_MUL_LAT = 2'd1;
   localparam logic [1:0] CSR_MEM_LAT = 2'd2;

   localparam lat_type ALU_LAT_RST = 3'd1;
   localparam lat_type MUL_LAT_RST = 3'd3;
   localparam lat_type MEM_LAT_RST = 3'd4;

   localparam reg_field_type REG_NONE = '1;
   localparam logic [WORD_W-1:0] TAG_EMPTY = '1;

   function automatic count_type sat_add(count_type a, lat_type b);
      logic [COUNT_BITS:0] s;
      s = {1'b0, a} + (COUNT_BITS+1)'(b);
      return s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
   endfunction

   // register field names an existing scoreboard entry
   function automatic logic reg_hit(reg_field_type f);
      return !f[REG_W-1] && (int'(f[REG_W-2:0]) < NUM_REGS);
   endfunction

   function automatic reg_addr_type reg_addr(reg_field_type f);
      logic [7:0] w;
      w = 8'(f[REG_W-2:0]);
      return w[REG_AW-1:0];
   endfunction

endpackage

[hdl/viis_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module viis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/vliw_in_order_issue_scoreboard.sv]
// In-order issue scoreboard for a three-slot VLIW machine.
// Depends on viis_pkg, viis_ram and vliw_in_order_issue_scoreboard_assert.svh.
//
// Usage:
//   req_* carries one operation per beat (valid/ready). rsp_* carries one
//   bundle per beat (valid/ready): zero to six empty bundles while the
//   operation's sources are not ready, then the bundle holding the operation
//   (rsp_run_end=1, rsp_program_end=req_last_op). csr_* writes the three unit
//   latencies (index 0 alu, 1 mul, 2 mem); write only while no operation is
//   in flight.
//   Timing: an accepted beat reads both sources from two scoreboard RAM
//   copies (registered read), then registers the max of the ready times
//   in CALC, then emits one bundle per cycle while the output is free.
//   req_ready is high only while no operation is in flight; the last
//   bundle sits in the output register while the next operation is
//   accepted.
//   Reset: counter cleared, all scoreboard entries read as zero (per-entry
//   valid flops), latencies 1/3/4. A last op clears counter and entries alike.
//   Stall: while rsp_ready is low the output register holds and bundle
//   generation pauses; nothing is lost.
module vliw_in_order_issue_scoreboard (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op_kind,
   input  logic signed [5:0]   req_dest_reg,
   input  logic signed [5:0]   req_src1_reg,
   input  logic signed [5:0]   req_src2_reg,
   input  logic signed [31:0]  req_immediate,
   input  logic signed [31:0]  req_op_tag,
   input  logic                req_last_op,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [31:0]         rsp_bundle_index,
   output logic [1:0]          rsp_out_unit,
   output logic signed [5:0]   rsp_out_dest,
   output logic signed [5:0]   rsp_out_src1,
   output logic signed [5:0]   rsp_out_src2,
   output logic signed [31:0]  rsp_out_immediate,
   output logic signed [31:0]  rsp_out_tag,
   output logic                rsp_run_end,
   output logic                rsp_program_end,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [2:0]          csr_wr_data
);

`include "vliw_in_order_issue_scoreboard_assert.svh"

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   viis_pkg::count_type cnt_ff, cnt_in;
   viis_pkg::count_type earliest_ff, earliest_in;
   logic [viis_pkg::WAIT_W-1:0] wait_cnt_ff, wait_cnt_in;
   logic [viis_pkg::NUM_REGS-1:0] vld_ff, vld_in;
   viis_pkg::lat_type alu_lat_ff, alu_lat_in, mul_lat_ff, mul_lat_in;
   viis_pkg::lat_type mem_lat_ff, mem_lat_in;

   // latched operation
   logic [1:0] kind_ff;
   viis_pkg::reg_field_type dest_ff, s1_ff, s2_ff;
   logic [viis_pkg::WORD_W-1:0] imm_ff, tag_ff;
   logic last_ff;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] o_idx_ff, o_idx_in;
   logic [1:0] o_unit_ff, o_unit_in;
   viis_pkg::reg_field_type o_dest_ff, o_dest_in, o_s1_ff, o_s1_in, o_s2_ff, o_s2_in;
   logic [viis_pkg::WORD_W-1:0] o_imm_ff, o_imm_in, o_tag_ff, o_tag_in;
   logic o_run_ff, o_run_in, o_prog_ff, o_prog_in;

   viis_pkg::count_type rd1, rd2, r1, r2;
   viis_pkg::count_type wr_data;
   viis_pkg::lat_type unit_lat;
   logic req_take, out_free, emit_go, need_wait, issue_now, wr_en;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_go   = (state_ff == ST_EMIT) && out_free;
   assign need_wait = (cnt_ff < earliest_ff) &&
                      (wait_cnt_ff != viis_pkg::WAIT_W'(viis_pkg::MAX_WAIT));
   assign issue_now = emit_go && !need_wait;
   assign wr_en     = issue_now && viis_pkg::reg_hit(dest_ff);

   always_comb begin
      case (kind_ff)
         viis_pkg::KIND_ALU: unit_lat = alu_lat_ff;
         viis_pkg::KIND_MUL: unit_lat = mul_lat_ff;
         viis_pkg::KIND_MEM: unit_lat = mem_lat_ff;
         default:            unit_lat = '0;
      endcase
   end
   assign wr_data = viis_pkg::sat_add(cnt_ff, unit_lat);

   // two copies so both sources are read in the same cycle
   viis_ram #(.WIDTH(viis_pkg::COUNT_BITS), .DEPTH(viis_pkg::NUM_REGS)) u_ram_s1 (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (viis_pkg::reg_addr(dest_ff)),
      .wr_data (wr_data),
      .rd_addr (viis_pkg::reg_addr(req_src1_reg)),
      .rd_data (rd1)
   );

   viis_ram #(.WIDTH(viis_pkg::COUNT_BITS), .DEPTH(viis_pkg::NUM_REGS)) u_ram_s2 (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (viis_pkg::reg_addr(dest_ff)),
      .wr_data (wr_data),
      .rd_addr (viis_pkg::reg_addr(req_src2_reg)),
      .rd_data (rd2)
   );

   // entries never written since the last clear read as zero
   assign r1 = (viis_pkg::reg_hit(s1_ff) && vld_ff[viis_pkg::reg_addr(s1_ff)]) ? rd1 : '0;
   assign r2 = (viis_pkg::reg_hit(s2_ff) && vld_ff[viis_pkg::reg_addr(s2_ff)]) ? rd2 : '0;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      earliest_in = earliest_ff;
      wait_cnt_in = wait_cnt_ff;
      vld_in      = vld_ff;
      alu_lat_in  = alu_lat_ff;
      mul_lat_in  = mul_lat_ff;
      mem_lat_in  = mem_lat_ff;

      if (csr_wr_en) begin
         case (csr_index)
            viis_pkg::CSR_ALU_LAT: alu_lat_in = csr_wr_data;
            viis_pkg::CSR_MUL_LAT: mul_lat_in = csr_wr_data;
            viis_pkg::CSR_MEM_LAT: mem_lat_in = csr_wr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            earliest_in = (r2 > r1) ? r2 : r1;
            wait_cnt_in = '0;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_go) begin
               cnt_in = viis_pkg::sat_add(cnt_ff, viis_pkg::lat_type'(1));
               if (need_wait) begin
                  wait_cnt_in = wait_cnt_ff + viis_pkg::WAIT_W'(1);
               end else begin
                  state_in = ST_IDLE;
                  if (wr_en) begin
                     vld_in[viis_pkg::reg_addr(dest_ff)] = 1'b1;
                  end
                  if (last_ff) begin
                     vld_in = '0;
                     cnt_in = '0;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      o_idx_in  = o_idx_ff;
      o_unit_in = o_unit_ff;
      o_dest_in = o_dest_ff;
      o_s1_in   = o_s1_ff;
      o_s2_in   = o_s2_ff;
      o_imm_in  = o_imm_ff;
      o_tag_in  = o_tag_ff;
      o_run_in  = o_run_ff;
      o_prog_in = o_prog_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         o_idx_in  = 32'(cnt_ff);
         o_unit_in = viis_pkg::KIND_NOP;
         o_dest_in = viis_pkg::REG_NONE;
         o_s1_in   = viis_pkg::REG_NONE;
         o_s2_in   = viis_pkg::REG_NONE;
         o_imm_in  = '0;
         o_tag_in  = viis_pkg::TAG_EMPTY;
         o_run_in  = 1'b0;
         o_prog_in = 1'b0;
         if (!need_wait) begin
            o_run_in  = 1'b1;
            o_prog_in = last_ff;
            // a nop issues as an empty slot
            if (kind_ff != viis_pkg::KIND_NOP) begin
               o_unit_in = kind_ff;
               o_dest_in = dest_ff;
               o_s1_in   = s1_ff;
               o_s2_in   = s2_ff;
               o_imm_in  = imm_ff;
               o_tag_in  = tag_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         earliest_ff  <= '0;
         wait_cnt_ff  <= '0;
         vld_ff       <= '0;
         alu_lat_ff   <= viis_pkg::ALU_LAT_RST;
         mul_lat_ff   <= viis_pkg::MUL_LAT_RST;
         mem_lat_ff   <= viis_pkg::MEM_LAT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         earliest_ff  <= earliest_in;
         wait_cnt_ff  <= wait_cnt_in;
         vld_ff       <= vld_in;
         alu_lat_ff   <= alu_lat_in;
         mul_lat_ff   <= mul_lat_in;
         mem_lat_ff   <= mem_lat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff <= req_op_kind;
         dest_ff <= req_dest_reg;
         s1_ff   <= req_src1_reg;
         s2_ff   <= req_src2_reg;
         imm_ff  <= req_immediate;
         tag_ff  <= req_op_tag;
         last_ff <= req_last_op;
      end
      o_idx_ff  <= o_idx_in;
      o_unit_ff <= o_unit_in;
      o_dest_ff <= o_dest_in;
      o_s1_ff   <= o_s1_in;
      o_s2_ff   <= o_s2_in;
      o_imm_ff  <= o_imm_in;
      o_tag_ff  <= o_tag_in;
      o_run_ff  <= o_run_in;
      o_prog_ff <= o_prog_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bundle_index  = o_idx_ff;
   assign rsp_out_unit      = o_unit_ff;
   assign rsp_out_dest      = o_dest_ff;
   assign rsp_out_src1      = o_s1_ff;
   assign rsp_out_src2      = o_s2_ff;
   assign rsp_out_immediate = o_imm_ff;
   assign rsp_out_tag       = o_tag_ff;
   assign rsp_run_end       = o_run_ff;
   assign rsp_program_end   = o_prog_ff;

   `VIIS_ASSERT_NOW(a_wait_cap, clock, reset, state_ff == ST_EMIT, wait_cnt_ff <= viis_pkg::WAIT_W'(viis_pkg::MAX_WAIT))
   `VIIS_ASSERT_NEXT(a_last_clears, clock, reset, issue_now && last_ff, cnt_ff == '0 && vld_ff == '0)
   `VIIS_ASSERT_NEXT(a_cnt_monotonic, clock, reset, !(issue_now && last_ff), cnt_ff >= $past(cnt_ff))
   `VIIS_ASSERT_NEXT(a_issue_done, clock, reset, issue_now, state_ff == ST_IDLE && rsp_valid_ff && rsp_run_end)
   `VIIS_ASSERT_NEXT(a_take_reads, clock, reset, req_take, state_ff == ST_CALC)

endmodule
